/* sv/skt_pkg.sv */
`default_nettype none

package skt_pkg;

   localparam int OP_W     = 2;
   localparam int KEY_W    = 32;
   localparam int TYPE_W   = 4;
   localparam int VALUE_W  = 64;
   localparam int STATUS_W = 2;

   localparam int REQ_FIELDS_W = OP_W + KEY_W + TYPE_W + VALUE_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;

   localparam int RSP_FIXED_W = STATUS_W + TYPE_W + VALUE_W;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [VALUE_W-1:0]     value_bits;
      logic [TYPE_W-1:0]      value_type;
      logic signed [KEY_W-1:0] key;
   } entry_type;

endpackage

`default_nettype wire

/* sv/sorted_key_table_core.sv */
// Channel   Direction  Handshake             Payload
// req_      in         req_tvalid/tready     operation, key, value_type, value_bits
// rsp_      out        rsp_tvalid/tready     status, found_type, found_value, entry_count
//
// One transfer in yields one transfer out. An item is accepted, then runs binary search
// steps, each a memory read and a compare (up to clog2(CAPACITY)+1 steps); an insert or a
// remove then moves the entries behind the position one at a time, an insert then writes
// the new entry, and at last the result fills the output register.
// Reset is synchronous and clears the entry count; the entry memory is not cleared.
// A new request is taken while an earlier response waits in the output register.
`default_nettype none

module sorted_key_table_core #(
   parameter int CAPACITY = 256
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // operation[1:0], key[33:2], value_type[37:34], value_bits[101:38], zero padding
   input  wire logic [skt_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // status[1:0], found_type[5:2], found_value[69:6], entry_count[CNT_W+69:70], zero padding
   output logic [((skt_pkg::RSP_FIXED_W + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] rsp_tdata
);

   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int RSP_F_W  = skt_pkg::RSP_FIXED_W + CNT_W;
   localparam int RSP_W    = ((RSP_F_W + 7) / 8) * 8;
   localparam int ENTRY_W  = skt_pkg::KEY_W + skt_pkg::TYPE_W + skt_pkg::VALUE_W;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SEARCH  = 3'd1;
   localparam logic [2:0] S_COMPARE = 3'd2;
   localparam logic [2:0] S_SHIFT   = 3'd3;
   localparam logic [2:0] S_INSERT  = 3'd4;
   localparam logic [2:0] S_DONE    = 3'd5;

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

   skt_pkg::entry_type mem [CAPACITY];

   logic [2:0]                      state_ff, state_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [CNT_W-1:0]                lo_ff, lo_in;
   logic [CNT_W-1:0]                hi_ff, hi_in;
   logic [CNT_W-1:0]                mid_ff, mid_in;
   logic [CNT_W-1:0]                pos_ff, pos_in;
   logic [CNT_W-1:0]                ptr_ff, ptr_in;
   logic [CNT_W-1:0]                rem_ff, rem_in;
   logic                            up_ff, up_in;
   logic                            wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0]               wr_addr_ff, wr_addr_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]                rsp_data_ff, rsp_data_in;
   logic [skt_pkg::OP_W-1:0]        op_ff, op_in;
   skt_pkg::entry_type              new_ff, new_in;
   logic [skt_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic [skt_pkg::TYPE_W-1:0]      ftype_ff, ftype_in;
   logic [skt_pkg::VALUE_W-1:0]     fval_ff, fval_in;
   skt_pkg::entry_type              rd_data_ff;

   logic                            rd_en;
   logic [ADDR_W-1:0]               rd_addr;
   logic                            wr_en;
   logic [ADDR_W-1:0]               wr_addr;
   skt_pkg::entry_type              wr_data;
   logic [CNT_W:0]                  mid_sum;
   logic                            hit;
   logic                            decide;
   logic [CNT_W-1:0]                dpos;
   logic [RSP_F_W-1:0]              rsp_fields;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign rsp_fields = {count_ff, fval_ff, ftype_ff, status_ff};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      pos_in       = pos_ff;
      ptr_in       = ptr_ff;
      rem_in       = rem_ff;
      up_in        = up_ff;
      wr_pend_in   = wr_pend_ff;
      wr_addr_in   = wr_addr_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      op_in        = op_ff;
      new_in       = new_ff;
      status_in    = status_ff;
      ftype_in     = ftype_ff;
      fval_in      = fval_ff;
      rd_en        = 1'b0;
      rd_addr      = mid_sum[ADDR_W:1];
      wr_en        = 1'b0;
      wr_addr      = wr_addr_ff;
      wr_data      = rd_data_ff;
      hit          = 1'b0;
      decide       = 1'b0;
      dpos         = lo_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in            = req_tdata[1:0];
               new_in.key       = req_tdata[33:2];
               new_in.value_type = req_tdata[37:34];
               new_in.value_bits = req_tdata[101:38];
               status_in        = skt_pkg::ST_OK;
               ftype_in         = '0;
               fval_in          = '0;
               lo_in            = '0;
               hi_in            = count_ff;
               case (req_tdata[1:0])
                  skt_pkg::OP_INSERT, skt_pkg::OP_LOOKUP, skt_pkg::OP_REMOVE: begin
                     state_in = S_SEARCH;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               rd_en    = 1'b1;
               rd_addr  = mid_sum[ADDR_W:1];
               mid_in   = mid_sum[CNT_W:1];
               state_in = S_COMPARE;
            end else begin
               decide = 1'b1;
               dpos   = lo_ff;
            end
         end
         S_COMPARE: begin
            if (new_ff.key > rd_data_ff.key) begin
               lo_in    = mid_ff + ONE_CNT;
               state_in = S_SEARCH;
            end else if (new_ff.key < rd_data_ff.key) begin
               hi_in    = mid_ff;
               state_in = S_SEARCH;
            end else begin
               hit    = 1'b1;
               decide = 1'b1;
               dpos   = mid_ff;
            end
         end
         S_SHIFT: begin
            if (wr_pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = wr_addr_ff;
               wr_data = rd_data_ff;
            end
            if (rem_ff != '0) begin
               rd_en      = 1'b1;
               rd_addr    = ptr_ff[ADDR_W-1:0];
               rem_in     = rem_ff - ONE_CNT;
               wr_pend_in = 1'b1;
               if (up_ff) begin
                  ptr_in     = ptr_ff - ONE_CNT;
                  wr_addr_in = ADDR_W'(ptr_ff + ONE_CNT);
               end else begin
                  ptr_in     = ptr_ff + ONE_CNT;
                  wr_addr_in = ADDR_W'(ptr_ff - ONE_CNT);
               end
            end else begin
               wr_pend_in = 1'b0;
               if (up_ff) begin
                  state_in = S_INSERT;
               end else begin
                  count_in = count_ff - ONE_CNT;
                  state_in = S_DONE;
               end
            end
         end
         S_INSERT: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff[ADDR_W-1:0];
            wr_data  = new_ff;
            count_in = count_ff + ONE_CNT;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'(rsp_fields);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (decide) begin
         pos_in     = dpos;
         wr_pend_in = 1'b0;
         state_in   = S_DONE;
         case (op_ff)
            skt_pkg::OP_INSERT: begin
               if (hit) begin
                  status_in = skt_pkg::ST_DUPLICATE;
               end else if (count_ff == CAP_CNT) begin
                  status_in = skt_pkg::ST_FULL;
               end else begin
                  rem_in   = count_ff - dpos;
                  ptr_in   = count_ff - ONE_CNT;
                  up_in    = 1'b1;
                  state_in = S_SHIFT;
               end
            end
            skt_pkg::OP_LOOKUP: begin
               if (hit) begin
                  ftype_in = rd_data_ff.value_type;
                  fval_in  = rd_data_ff.value_bits;
               end else begin
                  status_in = skt_pkg::ST_NOT_FOUND;
               end
            end
            skt_pkg::OP_REMOVE: begin
               if (hit) begin
                  rem_in   = count_ff - dpos - ONE_CNT;
                  ptr_in   = dpos + ONE_CNT;
                  up_in    = 1'b0;
                  state_in = S_SHIFT;
               end else begin
                  status_in = skt_pkg::ST_NOT_FOUND;
               end
            end
            default: begin
               status_in = skt_pkg::ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      pos_ff      <= pos_in;
      ptr_ff      <= ptr_in;
      rem_ff      <= rem_in;
      up_ff       <= up_in;
      wr_addr_ff  <= wr_addr_in;
      rsp_data_ff <= rsp_data_in;
      op_ff       <= op_in;
      new_ff      <= new_in;
      status_ff   <= status_in;
      ftype_ff    <= ftype_in;
      fval_ff     <= fval_in;
   end

endmodule

`default_nettype wire

/* sv/skt_checker.sv */
`default_nettype none

module skt_checker #(
   parameter int CAPACITY = 256
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   input wire logic req_tready,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [((skt_pkg::RSP_FIXED_W + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0]
                    rsp_tdata
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [skt_pkg::STATUS_W-1:0] status;
   logic [skt_pkg::TYPE_W-1:0]   found_type;
   logic [skt_pkg::VALUE_W-1:0]  found_value;
   logic [CNT_W-1:0]             entry_count;

   assign status      = rsp_tdata[1:0];
   assign found_type  = rsp_tdata[5:2];
   assign found_value = rsp_tdata[69:6];
   assign entry_count = rsp_tdata[CNT_W+69:70];

   // A stalled response keeps its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Only one request is in work at a time.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in work");

   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status != skt_pkg::ST_OK |-> found_type == '0 && found_value == '0)
      else $error("found fields set on a failed operation");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> entry_count <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status == skt_pkg::ST_FULL |-> entry_count == CNT_W'(CAPACITY))
      else $error("table full reported below capacity");

endmodule

bind sorted_key_table_core skt_checker #(.CAPACITY(CAPACITY)) u_skt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

/* bench/sorted_key_table_core_test.sv */
`default_nettype none

module sorted_key_table_core_test;

   localparam int TABLE_DEPTH = 256;
   localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int RSP_DATA_W = ((skt_pkg::RSP_FIXED_W + COUNT_W + 7) / 8) * 8;
   localparam logic [skt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int HOLD_OFF_CYCLES = 800;
   localparam int DRAIN_CYCLES = 300;

   typedef struct packed {
      logic [skt_pkg::OP_W-1:0] op;
      logic signed [skt_pkg::KEY_W-1:0] key;
      logic [skt_pkg::TYPE_W-1:0] tag;
      logic [skt_pkg::VALUE_W-1:0] bits;
   } table_request_type;

   typedef struct packed {
      logic [skt_pkg::STATUS_W-1:0] status;
      logic [skt_pkg::TYPE_W-1:0] found_type;
      logic [skt_pkg::VALUE_W-1:0] found_value;
      logic [COUNT_W-1:0] entry_count;
   } table_result_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [skt_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   table_request_type pending_requests[$];
   table_result_type expected_results[$];
   table_request_type offered_request;

   logic signed [skt_pkg::KEY_W-1:0] shadow_keys[0:TABLE_DEPTH-1];
   logic [skt_pkg::TYPE_W-1:0] shadow_tags[0:TABLE_DEPTH-1];
   logic [skt_pkg::VALUE_W-1:0] shadow_bits[0:TABLE_DEPTH-1];
   int shadow_count = 0;

   int accepted_count = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   sorted_key_table_core #(.CAPACITY(TABLE_DEPTH)) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int idle_phase();
      return (accepted_count / 100) % 4;
   endfunction

   function automatic bit sender_pauses();
      case (idle_phase())
         1: return $urandom_range(99) < 62;
         3: return $urandom_range(99) < 20;
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (idle_phase())
         2: return $urandom_range(99) < 62;
         3: return $urandom_range(99) < 20;
         default: return 1'b0;
      endcase
   endfunction

   function automatic void predict_table_result(input table_request_type r);
      table_result_type res;
      int pos;
      bit hit;
      res = '0;
      pos = 0;
      while (pos < shadow_count && shadow_keys[pos] < r.key) pos++;
      hit = (pos < shadow_count) && (shadow_keys[pos] == r.key);
      case (r.op)
         skt_pkg::OP_INSERT: begin
            if (hit) begin
               res.status = skt_pkg::ST_DUPLICATE;
            end else if (shadow_count >= TABLE_DEPTH) begin
               res.status = skt_pkg::ST_FULL;
            end else begin
               for (int i = shadow_count; i > pos; i--) begin
                  shadow_keys[i] = shadow_keys[i-1];
                  shadow_tags[i] = shadow_tags[i-1];
                  shadow_bits[i] = shadow_bits[i-1];
               end
               shadow_keys[pos] = r.key;
               shadow_tags[pos] = r.tag;
               shadow_bits[pos] = r.bits;
               shadow_count++;
            end
         end
         skt_pkg::OP_LOOKUP: begin
            if (hit) begin
               res.found_type = shadow_tags[pos];
               res.found_value = shadow_bits[pos];
            end else begin
               res.status = skt_pkg::ST_NOT_FOUND;
            end
         end
         skt_pkg::OP_REMOVE: begin
            if (hit) begin
               for (int i = pos; i + 1 < shadow_count; i++) begin
                  shadow_keys[i] = shadow_keys[i+1];
                  shadow_tags[i] = shadow_tags[i+1];
                  shadow_bits[i] = shadow_bits[i+1];
               end
               shadow_count--;
            end else begin
               res.status = skt_pkg::ST_NOT_FOUND;
            end
         end
         default: begin
         end
      endcase
      res.entry_count = COUNT_W'(shadow_count);
      expected_results.push_back(res);
   endfunction

   task automatic report_mismatch(input string what, input logic [skt_pkg::VALUE_W-1:0] want,
                                  input logic [skt_pkg::VALUE_W-1:0] got);
      $display("mismatch on %s: expected %h, got %h", what, want, got);
      mismatch_count++;
   endtask

   task automatic queue_request(input logic [skt_pkg::OP_W-1:0] op,
                                input logic [skt_pkg::KEY_W-1:0] key,
                                input logic [skt_pkg::TYPE_W-1:0] tag,
                                input logic [skt_pkg::VALUE_W-1:0] bits);
      table_request_type r;
      r.op = op;
      r.key = key;
      r.tag = tag;
      r.bits = bits;
      pending_requests.push_back(r);
   endtask

   function automatic logic [skt_pkg::OP_W-1:0] random_op();
      int w;
      w = $urandom_range(99);
      if (w < 40) return skt_pkg::OP_INSERT;
      if (w < 70) return skt_pkg::OP_LOOKUP;
      if (w < 95) return skt_pkg::OP_REMOVE;
      return OP_UNUSED;
   endfunction

   always @(posedge clock) begin : request_driver
      table_request_type next_request;
      logic [skt_pkg::REQ_DATA_W-1:0] word;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_requests.size() != 0 && !sender_pauses()) begin
            next_request = pending_requests.pop_front();
            word = '0;
            word[skt_pkg::REQ_FIELDS_W-1:0] = {next_request.bits, next_request.tag,
                                               next_request.key, next_request.op};
            offered_request <= next_request;
            req_tdata <= word;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : response_ready
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && accepted_count >= 60) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !receiver_stalls();
      end
   end

   always @(posedge clock) begin : transfer_checker
      table_result_type want;
      table_result_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[1:0];
            got.found_type = rsp_tdata[5:2];
            got.found_value = rsp_tdata[69:6];
            got.entry_count = rsp_tdata[70 +: COUNT_W];
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected response", '0, rsp_tdata[63:0]);
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", skt_pkg::VALUE_W'(want.status),
                                  skt_pkg::VALUE_W'(got.status));
               if (got.found_type !== want.found_type)
                  report_mismatch("found_type", skt_pkg::VALUE_W'(want.found_type),
                                  skt_pkg::VALUE_W'(got.found_type));
               if (got.found_value !== want.found_value)
                  report_mismatch("found_value", want.found_value, got.found_value);
               if (got.entry_count !== want.entry_count)
                  report_mismatch("entry_count", skt_pkg::VALUE_W'(want.entry_count),
                                  skt_pkg::VALUE_W'(got.entry_count));
            end
         end
         if (req_tvalid && req_tready) begin
            predict_table_result(offered_request);
            accepted_count <= accepted_count + 1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("sorted_key_table_core_test: FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      logic [skt_pkg::KEY_W-1:0] key_pool[24];
      logic [skt_pkg::KEY_W-1:0] fill_keys[$];
      logic [skt_pkg::KEY_W-1:0] removal_keys[$];
      logic [skt_pkg::KEY_W-1:0] k;
      int idx;

      queue_request(skt_pkg::OP_LOOKUP, 32'd0, 4'd3, 64'h1);
      queue_request(skt_pkg::OP_REMOVE, 32'd5, 4'd0, 64'h0);
      queue_request(skt_pkg::OP_INSERT, 32'd0, 4'd0, 64'h0);
      queue_request(skt_pkg::OP_INSERT, 32'h7fff_ffff, 4'd15, 64'hffff_ffff_ffff_ffff);
      queue_request(skt_pkg::OP_INSERT, 32'h8000_0000, 4'd11, 64'h0123_4567_89ab_cdef);
      queue_request(skt_pkg::OP_INSERT, 32'hffff_ffff, 4'd5, {$urandom, $urandom});
      queue_request(skt_pkg::OP_INSERT, 32'd1, 4'd7, 64'h8000_0000_0000_0001);
      queue_request(skt_pkg::OP_INSERT, 32'd0, 4'd9, 64'h5555);
      queue_request(skt_pkg::OP_LOOKUP, 32'h8000_0000, 4'd0, 64'h0);
      queue_request(skt_pkg::OP_LOOKUP, 32'h7fff_ffff, 4'd0, 64'h0);
      queue_request(skt_pkg::OP_LOOKUP, 32'hffff_ffff, 4'd0, 64'h0);
      queue_request(skt_pkg::OP_LOOKUP, 32'd0, 4'd15, 64'hffff_ffff_ffff_ffff);
      queue_request(skt_pkg::OP_LOOKUP, 32'd1, 4'd0, 64'h0);
      queue_request(skt_pkg::OP_LOOKUP, 32'd2, 4'd0, 64'h0);
      queue_request(OP_UNUSED, 32'h7fff_ffff, 4'd15, 64'hffff_ffff_ffff_ffff);
      queue_request(skt_pkg::OP_REMOVE, 32'd0, 4'd0, 64'h0);
      queue_request(skt_pkg::OP_REMOVE, 32'h8000_0000, 4'd0, 64'h0);
      queue_request(skt_pkg::OP_REMOVE, 32'h7fff_ffff, 4'd0, 64'h0);
      queue_request(skt_pkg::OP_LOOKUP, 32'd0, 4'd0, 64'h0);
      queue_request(skt_pkg::OP_REMOVE, 32'hffff_ffff, 4'd0, 64'h0);
      queue_request(skt_pkg::OP_REMOVE, 32'd1, 4'd0, 64'h0);
      queue_request(OP_UNUSED, 32'd0, 4'd0, 64'h0);

      key_pool[0] = 32'd0;
      key_pool[1] = 32'hffff_ffff;
      key_pool[2] = 32'h7fff_ffff;
      key_pool[3] = 32'h8000_0000;
      for (int i = 4; i < 24; i++)
         key_pool[i] = (i % 2) ? $urandom : 32'($urandom_range(40)) - 32'd20;

      for (int i = 0; i < 500; i++)
         queue_request(random_op(), key_pool[$urandom_range(23)], 4'($urandom_range(15)),
                       {$urandom, $urandom});

      for (int i = 0; i < 280; i++) begin
         k = $urandom;
         fill_keys.push_back(k);
         queue_request(skt_pkg::OP_INSERT, k, 4'($urandom_range(15)), {$urandom, $urandom});
      end

      for (int i = 0; i < 40; i++) begin
         case ($urandom_range(3))
            0: queue_request(skt_pkg::OP_INSERT, $urandom, 4'($urandom_range(15)),
                             {$urandom, $urandom});
            1: queue_request(skt_pkg::OP_INSERT, fill_keys[$urandom_range(279)],
                             4'($urandom_range(15)), {$urandom, $urandom});
            2: queue_request(skt_pkg::OP_LOOKUP, fill_keys[$urandom_range(279)],
                             4'($urandom_range(15)), {$urandom, $urandom});
            default: queue_request(OP_UNUSED, $urandom, 4'($urandom_range(15)),
                                   {$urandom, $urandom});
         endcase
      end

      removal_keys = fill_keys;
      while (removal_keys.size() != 0) begin
         idx = $urandom_range(removal_keys.size() - 1);
         queue_request(skt_pkg::OP_REMOVE, removal_keys[idx], 4'($urandom_range(15)),
                       {$urandom, $urandom});
         removal_keys.delete(idx);
         if ($urandom_range(3) == 0)
            queue_request(skt_pkg::OP_LOOKUP, fill_keys[$urandom_range(279)],
                          4'($urandom_range(15)), {$urandom, $urandom});
      end

      for (int i = 0; i < 100; i++) begin
         k = ($urandom_range(1) == 0) ? key_pool[$urandom_range(23)] : $urandom;
         queue_request(random_op(), k, 4'($urandom_range(15)), {$urandom, $urandom});
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      do
         @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("sorted_key_table_core_test: PASS");
      else
         $display("sorted_key_table_core_test: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
